@@ rtl/bpe_pkg.sv @@
`default_nettype none
package bpe_pkg;

    localparam int VAL_W = 64;
    localparam int SUB_W = VAL_W + 1;
    localparam int PAD_W = 70;
    localparam int ARC_MUL = 40;

    localparam logic [1:0] K_LEN  = 2'd0;
    localparam logic [1:0] K_INT  = 2'd1;
    localparam logic [1:0] K_ARC  = 2'd2;
    localparam logic [1:0] K_NONE = 2'd3;

    localparam logic [1:0] P_FIRST  = 2'd0;
    localparam logic [1:0] P_SECOND = 2'd1;
    localparam logic [1:0] P_LATER  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        M_UNS,
        M_SGN,
        M_B128
    } t_mode;

    typedef struct packed {
        logic load;
        logic calc;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic fin;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/bpe_ctrl.sv @@
`default_nettype none
module bpe_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    input  wire bpe_pkg::t_stat i_stat,
    output bpe_pkg::t_cmd      o_cmd
);
    import bpe_pkg::*;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && !i_stat.skip) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free && i_stat.fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_cmd.emit) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule
`default_nettype wire

@@ rtl/bpe_dp.sv @@
`default_nettype none
module bpe_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [1:0]                   i_kind,
    input  wire logic signed [bpe_pkg::VAL_W-1:0] i_value,
    input  wire logic                         i_last_arc,
    input  wire bpe_pkg::t_cmd                i_cmd,
    output bpe_pkg::t_stat                    o_stat,
    output logic [7:0]                        o_out_byte,
    output logic                              o_last_byte
);
    import bpe_pkg::*;

    logic [SUB_W-1:0] r_val, n_val;
    t_mode            r_mode, n_mode;
    logic             r_pref, n_pref;
    logic [3:0]       r_idx, n_idx;
    logic [1:0]       r_arc_pos, n_arc_pos;
    logic [1:0]       r_held, n_held;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;

    logic [VAL_W-1:0] w_v;
    logic [1:0]       w_first;
    logic [SUB_W-1:0] w_sum;
    logic [PAD_W-1:0] w_pad;
    logic [3:0]       w_top_uns, w_top_sgn, w_top_b128, w_top;
    logic [6:0]       w_grp_base;
    logic [6:0]       w_grp;
    logic [7:0]       w_sel;

    assign w_v     = i_value;
    assign w_first = (w_v > 64'd2) ? 2'd2 : w_v[1:0];
    assign w_sum   = {1'b0, w_v} + SUB_W'(r_held * 7'(ARC_MUL));
    assign w_pad   = {{(PAD_W-SUB_W){1'b0}}, r_val};

    assign o_stat.skip = (i_kind == K_NONE)
                      || (i_kind == K_ARC && r_arc_pos == P_FIRST && !i_last_arc);
    assign o_stat.fin  = !r_pref && (r_idx == 4'd0);

    // byte count searches
    always_comb begin
        w_top_uns = 4'd0;
        for (int g = 1; g < 8; g++) begin
            if (r_val[8*g +: 8] != 8'd0) begin
                w_top_uns = 4'(g);
            end
        end
    end

    always_comb begin
        logic [VAL_W-1:0] s;
        logic [VAL_W-1:0] ones;
        w_top_sgn = 4'd7;
        for (int n = 7; n >= 1; n--) begin
            s    = r_val[VAL_W-1:0] >> (8*n - 1);
            ones = {VAL_W{1'b1}} >> (8*n - 1);
            if (s == '0 || s == ones) begin
                w_top_sgn = 4'(n - 1);
            end
        end
    end

    always_comb begin
        w_top_b128 = 4'd0;
        for (int g = 1; g < 10; g++) begin
            if (w_pad[7*g +: 7] != 7'd0) begin
                w_top_b128 = 4'(g);
            end
        end
    end

    always_comb begin
        case (r_mode)
            M_UNS:   w_top = w_top_uns;
            M_SGN:   w_top = w_top_sgn;
            M_B128:  w_top = w_top_b128;
            default: w_top = w_top_uns;
        endcase
    end

    assign w_grp_base = 7'(r_idx) * 7'd7;
    assign w_grp      = w_pad[w_grp_base +: 7];
    assign w_sel      = r_val[{r_idx[2:0], 3'b000} +: 8];

    always_comb begin
        n_val     = r_val;
        n_mode    = r_mode;
        n_pref    = r_pref;
        n_idx     = r_idx;
        n_arc_pos = r_arc_pos;
        n_held    = r_held;
        n_byte    = r_byte;
        n_last    = r_last;
        if (i_cmd.load) begin
            n_pref = 1'b0;
            n_mode = M_UNS;
            n_val  = {1'b0, w_v};
            case (i_kind)
                K_LEN: begin
                    if (w_v[VAL_W-1]) begin
                        n_val = '0;
                    end else if (w_v[VAL_W-1:7] != '0) begin
                        n_pref = 1'b1;
                    end
                end
                K_INT: begin
                    n_mode = M_SGN;
                end
                K_ARC: begin
                    if (r_arc_pos == P_FIRST) begin
                        n_held = w_first;
                        n_val  = SUB_W'(w_first);
                        if (!i_last_arc) begin
                            n_arc_pos = P_SECOND;
                        end
                    end else begin
                        n_mode    = M_B128;
                        n_arc_pos = i_last_arc ? P_FIRST : P_LATER;
                        if (r_arc_pos == P_SECOND) begin
                            n_val = w_sum;
                        end
                    end
                end
                default: begin
                    n_val = r_val;
                end
            endcase
        end
        if (i_cmd.calc) begin
            n_idx = w_top;
        end
        if (i_cmd.emit) begin
            if (r_pref) begin
                n_byte = 8'h80 | {4'd0, r_idx + 4'd1};
                n_last = 1'b0;
                n_pref = 1'b0;
            end else begin
                if (r_mode == M_B128) begin
                    n_byte = {(r_idx != 4'd0), w_grp};
                end else begin
                    n_byte = w_sel;
                end
                n_last = (r_idx == 4'd0);
                n_idx  = r_idx - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arc_pos <= P_FIRST;
            r_held    <= 2'd0;
        end else begin
            r_arc_pos <= n_arc_pos;
            r_held    <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_mode <= n_mode;
        r_pref <= n_pref;
        r_idx  <= n_idx;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

endmodule
`default_nettype wire

@@ rtl/ber_primitive_encoder.sv @@
// flow: accept, size the value, then one byte per cycle while the output is not stalled
// an item of n bytes is sized in S_CALC and emitted in S_EMIT before the next accept
// (n is 1 to 9 for a length, 1 to 8 for an integer, 1 to 10 for an arc)
// an item with no bytes (held first arc, kind three) is dropped and the encoder stays idle
// the output register lets the next request in while the last byte waits
// synchronous active-low reset clears the controller and the arc state
`default_nettype none
module ber_primitive_encoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [1:0]                        i_kind,
    input  wire logic signed [bpe_pkg::VAL_W-1:0]  i_value,
    input  wire logic                              i_last_arc,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [7:0]                             o_out_byte,
    output logic                                   o_last_byte
);
    import bpe_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    bpe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    bpe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_last_arc  (i_last_arc),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
`default_nettype wire

@@ rtl/bpe_checker.sv @@
`default_nettype none
module bpe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [1:0]  i_kind,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_last_byte
);
    import bpe_pkg::*;

    // stalled byte holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_last_byte))
        else $error("stalled output changed");

    // more bytes of this request pending, so no new request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_byte |-> !o_ready)
        else $error("ready while request still emitting");

    // length and integer always produce bytes
    a_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_kind == K_LEN || i_kind == K_INT) |=> !o_ready)
        else $error("length or integer request produced no work");

    // unused kind is dropped at once
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_kind == K_NONE |=> o_ready)
        else $error("unused kind stalled input");

endmodule

bind ber_primitive_encoder bpe_checker u_bpe_checker (.*);
`default_nettype wire
